// File: rtl/cslc_pkg.sv
// shared types and constants for the co sensor link controller
package cslc_pkg;

    localparam int TIMER_WIDTH = 24;
    localparam int CNT_WIDTH   = 20;
    localparam int ADDR_WIDTH  = 5;

    localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
    localparam logic [7:0]  REPLY_CODE = 8'h86;
    localparam logic [15:0] MAX_TENTHS = 16'd5000;

    localparam logic [TIMER_WIDTH-1:0] POLL_RESET   = TIMER_WIDTH'(60000);
    localparam logic [7:0]             GAS_RESET    = 8'd4;
    localparam logic [CNT_WIDTH-1:0]   SETTLE_RESET = CNT_WIDTH'(180000);
    localparam logic [CNT_WIDTH-1:0]   WAKE_RESET   = CNT_WIDTH'(30000);
    localparam logic [CNT_WIDTH-1:0]   REPLY_RESET  = CNT_WIDTH'(3000);
    localparam logic [CNT_WIDTH-1:0]   SLEEP_RESET  = CNT_WIDTH'(2000);

    typedef enum logic [2:0] {
        REG_QUERY_MODE   = 3'd0,
        REG_POLL_INT     = 3'd1,
        REG_GAS_TYPE     = 3'd2,
        REG_SETTLE       = 3'd3,
        REG_WAKE_WAIT    = 3'd4,
        REG_REPLY_TMO    = 3'd5,
        REG_SLEEP_DELAY  = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WAKE  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_SLEEP = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_OK      = 3'd1,
        ST_CSUM    = 3'd2,
        ST_HDR     = 3'd3,
        ST_RANGE   = 3'd4,
        ST_TIMEOUT = 3'd5
    } status_t;

    typedef struct packed {
        logic                   query_mode;
        logic [TIMER_WIDTH-1:0] poll_interval_ms;
        logic [7:0]             gas_type_code;
        logic [CNT_WIDTH-1:0]   settle_ms;
        logic [CNT_WIDTH-1:0]   wake_wait_ms;
        logic [CNT_WIDTH-1:0]   reply_timeout_ms;
        logic [CNT_WIDTH-1:0]   sleep_delay_ms;
    } cslc_cfg_t;

    typedef struct packed {
        command_t    send_command;
        logic        reading_valid;
        logic [12:0] co_tenths_ppm;
        status_t     frame_status;
    } cslc_result_t;

endpackage

// File: rtl/cslc_core.sv
// frame assembly, checksum, settling and query sequencing
module cslc_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  kind,
    input  logic [7:0]            rx_byte,
    input  cslc_pkg::cslc_cfg_t   cfg,
    output cslc_pkg::cslc_result_t result
);
    import cslc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAKE = 2'd1,
        PH_READ = 2'd2,
        PH_WAIT = 2'd3
    } phase_t;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
    localparam logic [CNT_WIDTH-1:0]   CNT_MAX   = {CNT_WIDTH{1'b1}};
    localparam logic [3:0]             LAST_IDX  = 4'd8;

    logic                   settling_reg, settling_next;
    logic [CNT_WIDTH-1:0]   settle_cnt_reg, settle_cnt_next;
    phase_t                 phase_reg, phase_next;
    logic [CNT_WIDTH-1:0]   phase_tmr_reg, phase_tmr_next;
    logic [TIMER_WIDTH-1:0] since_sleep_reg, since_sleep_next;
    logic [3:0]             idx_reg, idx_next;
    logic [7:0]             sum_reg, sum_next;
    logic [7:0]             b1_reg, b1_next;
    logic [7:0]             b2_reg, b2_next;
    logic [7:0]             b3_reg, b3_next;
    logic [7:0]             b4_reg, b4_next;
    logic [7:0]             b5_reg, b5_next;

    logic                   do_gather;
    logic                   hdr_ok;
    logic [15:0]            raw;
    logic [CNT_WIDTH-1:0]   tmr_inc;

    always_comb
    begin
        settling_next    = settling_reg;
        settle_cnt_next  = settle_cnt_reg;
        phase_next       = phase_reg;
        phase_tmr_next   = phase_tmr_reg;
        since_sleep_next = since_sleep_reg;
        idx_next         = idx_reg;
        sum_next         = sum_reg;
        b1_next          = b1_reg;
        b2_next          = b2_reg;
        b3_next          = b3_reg;
        b4_next          = b4_reg;
        b5_next          = b5_reg;
        result.send_command  = CMD_NONE;
        result.reading_valid = 1'b0;
        result.co_tenths_ppm = '0;
        result.frame_status  = ST_NONE;
        do_gather = 1'b0;
        hdr_ok    = 1'b0;
        raw       = '0;
        tmr_inc   = (phase_tmr_reg == CNT_MAX) ? CNT_MAX : phase_tmr_reg + 1'b1;

        if (accept)
        begin
            if (kind)
            begin
                if (since_sleep_reg != TIMER_MAX)
                    since_sleep_next = since_sleep_reg + 1'b1;
                if (settling_reg && settle_cnt_reg != CNT_MAX)
                    settle_cnt_next = settle_cnt_reg + 1'b1;
            end
            if (settling_reg && settle_cnt_next >= cfg.settle_ms)
                settling_next = 1'b0;

            if (!settling_next)
            begin
                if (cfg.query_mode && kind)
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if (since_sleep_next >= cfg.poll_interval_ms)
                            begin
                                result.send_command = CMD_WAKE;
                                phase_next     = PH_WAKE;
                                phase_tmr_next = '0;
                                idx_next       = '0;
                            end
                        end
                        PH_WAKE:
                        begin
                            phase_tmr_next = tmr_inc;
                            if (tmr_inc >= cfg.wake_wait_ms)
                            begin
                                result.send_command = CMD_READ;
                                phase_next     = PH_READ;
                                phase_tmr_next = '0;
                                idx_next       = '0;
                            end
                        end
                        PH_READ:
                        begin
                            phase_tmr_next = tmr_inc;
                            if (tmr_inc >= cfg.reply_timeout_ms)
                            begin
                                result.frame_status = ST_TIMEOUT;
                                phase_next     = PH_WAIT;
                                phase_tmr_next = '0;
                            end
                        end
                        default:
                        begin
                            phase_tmr_next = tmr_inc;
                            if (tmr_inc >= cfg.sleep_delay_ms)
                            begin
                                result.send_command = CMD_SLEEP;
                                since_sleep_next = '0;
                                phase_next       = PH_IDLE;
                            end
                        end
                    endcase
                end
                else if (!kind)
                begin
                    do_gather = !cfg.query_mode || (phase_reg == PH_READ);
                end
            end
        end

        // byte gathering with a running checksum over bytes one to seven
        if (do_gather && !(idx_reg == '0 && rx_byte != SYNC_BYTE))
        begin
            idx_next = (idx_reg == LAST_IDX) ? 4'd0 : idx_reg + 1'b1;
            case (idx_reg)
                4'd0: ;
                4'd1:
                begin
                    b1_next  = rx_byte;
                    sum_next = rx_byte;
                end
                4'd2:
                begin
                    b2_next  = rx_byte;
                    sum_next = sum_reg + rx_byte;
                end
                4'd3:
                begin
                    b3_next  = rx_byte;
                    sum_next = sum_reg + rx_byte;
                end
                4'd4:
                begin
                    b4_next  = rx_byte;
                    sum_next = sum_reg + rx_byte;
                end
                4'd5:
                begin
                    b5_next  = rx_byte;
                    sum_next = sum_reg + rx_byte;
                end
                4'd6, 4'd7: sum_next = sum_reg + rx_byte;
                default:
                begin
                    // last byte: judge the frame
                    if (cfg.query_mode)
                    begin
                        hdr_ok     = (b1_reg == REPLY_CODE);
                        raw        = {b2_reg, b3_reg};
                        phase_next     = PH_WAIT;
                        phase_tmr_next = '0;
                    end
                    else
                    begin
                        hdr_ok = (b1_reg == cfg.gas_type_code);
                        raw    = {b4_reg, b5_reg};
                    end
                    if (!hdr_ok)
                        result.frame_status = ST_HDR;
                    else if (8'(sum_reg + rx_byte) != 8'd0)
                        result.frame_status = ST_CSUM;
                    else if (raw > MAX_TENTHS)
                        result.frame_status = ST_RANGE;
                    else
                    begin
                        result.frame_status  = ST_OK;
                        result.reading_valid = 1'b1;
                        result.co_tenths_ppm = raw[12:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settling_reg    <= 1'b1;
            settle_cnt_reg  <= '0;
            phase_reg       <= PH_IDLE;
            phase_tmr_reg   <= '0;
            since_sleep_reg <= '0;
            idx_reg         <= '0;
        end
        else
        begin
            settling_reg    <= settling_next;
            settle_cnt_reg  <= settle_cnt_next;
            phase_reg       <= phase_next;
            phase_tmr_reg   <= phase_tmr_next;
            since_sleep_reg <= since_sleep_next;
            idx_reg         <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        b1_reg  <= b1_next;
        b2_reg  <= b2_next;
        b3_reg  <= b3_next;
        b4_reg  <= b4_next;
        b5_reg  <= b5_next;
    end

    // settling never comes back once it has ended
    a_settle_once: assert property (@(posedge clk) disable iff (!rst_n)
        !settling_reg |=> !settling_reg)
        else $error("settling reasserted");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("frame index out of range");

    a_cmd_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.send_command != CMD_NONE) |-> (kind && result.frame_status == ST_NONE))
        else $error("command issued on a byte request");

    a_reading_ok: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (result.reading_valid == (result.frame_status == ST_OK)))
        else $error("reading flag disagrees with status");

endmodule

// File: rtl/co_sensor_link_controller.sv
// top level of the co sensor link controller: register port, core and output skid stage
//
// usage
//   input channel: one request per received uart byte (kind 0, rx_byte) or
//   per millisecond tick (kind 1), taken when in_valid is high and in_stall low
//   output channel: exactly one result per input request, in order, carrying
//   send_command, reading_valid, co_tenths_ppm and frame_status
//   a result is registered in the output register, or in the skid entry while
//   the output stalls; throughput: one request per cycle while in_stall is low;
//   core state and checksum update in the cycle of acceptance, so nothing iterates
//   stalling: an output register plus one skid entry hold results; one more
//   request is taken after the receiver stalls, then in_stall stays high while
//   the skid entry is full and drops at the edge where the receiver takes the
//   held result
//   reset (rst_n low, asynchronous): registers return to their defaults, the
//   settling window restarts, the query sequencer goes idle and both output
//   stages empty
//   configuration: apb writes at byte address 4 * register index, always ready;
//   write it only while no result is outstanding
module co_sensor_link_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cslc_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [7:0]                      rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      send_command,
    output logic                            reading_valid,
    output logic [12:0]                     co_tenths_ppm,
    output logic [2:0]                      frame_status
);
    import cslc_pkg::*;

    cslc_cfg_t    cfg_reg;
    cslc_result_t core_result;
    cslc_result_t out_reg;
    cslc_result_t skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         accept;
    logic         out_fire;
    logic         cfg_write;
    reg_index_t   reg_sel;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.query_mode       <= 1'b0;
            cfg_reg.poll_interval_ms <= POLL_RESET;
            cfg_reg.gas_type_code    <= GAS_RESET;
            cfg_reg.settle_ms        <= SETTLE_RESET;
            cfg_reg.wake_wait_ms     <= WAKE_RESET;
            cfg_reg.reply_timeout_ms <= REPLY_RESET;
            cfg_reg.sleep_delay_ms   <= SLEEP_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_QUERY_MODE:  cfg_reg.query_mode       <= pwdata[0];
                REG_POLL_INT:    cfg_reg.poll_interval_ms <= pwdata[TIMER_WIDTH-1:0];
                REG_GAS_TYPE:    cfg_reg.gas_type_code    <= pwdata[7:0];
                REG_SETTLE:      cfg_reg.settle_ms        <= pwdata[CNT_WIDTH-1:0];
                REG_WAKE_WAIT:   cfg_reg.wake_wait_ms     <= pwdata[CNT_WIDTH-1:0];
                REG_REPLY_TMO:   cfg_reg.reply_timeout_ms <= pwdata[CNT_WIDTH-1:0];
                REG_SLEEP_DELAY: cfg_reg.sleep_delay_ms   <= pwdata[CNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_QUERY_MODE:  prdata = {31'd0, cfg_reg.query_mode};
            REG_POLL_INT:    prdata = 32'(cfg_reg.poll_interval_ms);
            REG_GAS_TYPE:    prdata = {24'd0, cfg_reg.gas_type_code};
            REG_SETTLE:      prdata = 32'(cfg_reg.settle_ms);
            REG_WAKE_WAIT:   prdata = 32'(cfg_reg.wake_wait_ms);
            REG_REPLY_TMO:   prdata = 32'(cfg_reg.reply_timeout_ms);
            REG_SLEEP_DELAY: prdata = 32'(cfg_reg.sleep_delay_ms);
            default:         prdata = '0;
        endcase
    end

    // input side: stall only while the skid entry holds a result
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    cslc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .kind    (kind),
        .rx_byte (rx_byte),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= core_result;
        end
        else if (accept)
        begin
            skid_reg <= core_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign send_command  = out_reg.send_command;
    assign reading_valid = out_reg.reading_valid;
    assign co_tenths_ppm = out_reg.co_tenths_ppm;
    assign frame_status  = out_reg.frame_status;

endmodule
